/* sv/bpk_pkg.sv */
`default_nettype none

package bpk_pkg;

   localparam int unsigned ModeWidth  = 3;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned PosWidth   = 3;

   localparam logic [ModeWidth-1:0] MODE_BIT     = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_BYTE    = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_ALIGNED = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_CHUNK   = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_FLUSH   = 3'd4;

   localparam logic [CountWidth-1:0] FULL_BYTE_BITS = 4'd8;
   localparam logic [CountWidth-1:0] ONE_BIT        = 4'd1;

   typedef struct packed {
      logic [ModeWidth-1:0]  mode;
      logic [ByteWidth-1:0]  data_byte;
      logic [CountWidth-1:0] bit_count;
   } item_type;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 is_final;
   } result_type;

endpackage

`default_nettype wire

/* sv/bpk_req_if.sv */
`default_nettype none

interface bpk_req_if;
   logic                              valid;
   logic                              ready;
   logic [bpk_pkg::ModeWidth-1:0]     mode;
   logic [bpk_pkg::ByteWidth-1:0]     data_byte;
   logic [bpk_pkg::CountWidth-1:0]    bit_count;

   modport source (output valid, output mode, output data_byte, output bit_count,
                   input ready);
   modport sink   (input valid, input mode, input data_byte, input bit_count,
                   output ready);
endinterface

`default_nettype wire

/* sv/bpk_rsp_if.sv */
`default_nettype none

interface bpk_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpk_pkg::ByteWidth-1:0] out_byte;
   logic                          is_final;

   modport source (output valid, output out_byte, output is_final, input ready);
   modport sink   (input valid, input out_byte, input is_final, output ready);
endinterface

`default_nettype wire

/* sv/bpk_in_stage.sv */
`default_nettype none

module bpk_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire bpk_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_take,
   output bpk_pkg::item_type      out_item
);
   import bpk_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // The stage refills in the same cycle that the core drains it.
   assign in_ready = !valid_ff || out_take;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

/* sv/bpk_pack_core.sv */
`default_nettype none

module bpk_pack_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire bpk_pkg::item_type item,
   output logic                   item_take,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bpk_pkg::result_type    rsp_result
);
   import bpk_pkg::*;

   logic [ByteWidth-1:0]    partial_ff;
   logic [ByteWidth-1:0]    partial_in;
   logic [PosWidth-1:0]     pos_ff;
   logic [PosWidth-1:0]     pos_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   result_type              result_ff;
   result_type              result_in;

   logic                    append_en;
   logic [CountWidth-1:0]   n_bits;
   logic [ByteWidth-1:0]    mask;
   logic [2*ByteWidth-1:0]  acc;
   logic [CountWidth-1:0]   total;
   logic                    emit;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);

   // Number of bits that the item appends; zero means no append at all.
   always_comb begin
      append_en = 1'b0;
      n_bits    = '0;
      case (item.mode)
         MODE_BIT: begin
            append_en = 1'b1;
            n_bits    = ONE_BIT;
         end
         MODE_BYTE: begin
            append_en = 1'b1;
            n_bits    = FULL_BYTE_BITS;
         end
         MODE_CHUNK: begin
            append_en = (item.bit_count != '0);
            n_bits    = (item.bit_count > FULL_BYTE_BITS) ? FULL_BYTE_BITS : item.bit_count;
         end
         default: begin
            append_en = 1'b0;
            n_bits    = '0;
         end
      endcase
   end

   assign mask  = 8'hFF >> (FULL_BYTE_BITS - n_bits);
   assign acc   = {{ByteWidth{1'b0}}, partial_ff}
                | ({{ByteWidth{1'b0}}, item.data_byte & mask} << pos_ff);
   assign total = {1'b0, pos_ff} + n_bits;

   always_comb begin
      partial_in          = partial_ff;
      pos_in              = pos_ff;
      emit                = 1'b0;
      result_in.out_byte  = acc[ByteWidth-1:0];
      result_in.is_final  = 1'b0;
      if (append_en) begin
         if (total >= FULL_BYTE_BITS) begin
            emit       = 1'b1;
            partial_in = acc[2*ByteWidth-1:ByteWidth];
            pos_in     = total[PosWidth-1:0];
         end else begin
            partial_in = acc[ByteWidth-1:0];
            pos_in     = total[PosWidth-1:0];
         end
      end else if (item.mode == MODE_ALIGNED) begin
         // The aligned word replaces the slot; the bit position is kept.
         emit               = 1'b1;
         result_in.out_byte = item.data_byte;
         partial_in         = '0;
      end else if (item.mode == MODE_FLUSH) begin
         emit               = (pos_ff != '0);
         result_in.out_byte = partial_ff;
         result_in.is_final = 1'b1;
         partial_in         = '0;
         pos_in             = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            partial_ff <= partial_in;
            pos_ff     <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

/* sv/lsb_first_bit_packer_top.sv */
// Packs groups of 1 to 8 bits into a byte stream, least significant bit first.
// A word enters a one-deep input register, is packed combinationally against
// the pending partial byte and bit position, and any completed byte lands in
// the output register. One word is accepted every cycle as long as finished
// bytes are taken as they come. While a byte waits at the output, the core
// cannot take the word in the input register; once that register holds a
// word, the input stalls until the byte is taken. A completed byte passes
// through the input and output registers before it can be taken. Words that
// complete no byte (most single bits, short chunks, a flush with nothing
// pending, unused modes) give no output word. A flush marks its tail byte
// with is_final.
`default_nettype none

module lsb_first_bit_packer_top (
   input  wire logic clock,
   input  wire logic reset,
   bpk_req_if.sink   req,
   bpk_rsp_if.source rsp
);
   import bpk_pkg::*;

   item_type   req_item;
   item_type   core_item;
   logic       core_valid;
   logic       core_take;
   result_type core_result;

   assign req_item.mode      = req.mode;
   assign req_item.data_byte = req.data_byte;
   assign req_item.bit_count = req.bit_count;

   bpk_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_item   (req_item),
      .out_valid (core_valid),
      .out_take  (core_take),
      .out_item  (core_item)
   );

   bpk_pack_core u_pack_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (core_valid),
      .item       (core_item),
      .item_take  (core_take),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_result (core_result)
   );

   assign rsp.out_byte = core_result.out_byte;
   assign rsp.is_final = core_result.is_final;

endmodule

`default_nettype wire

/* sv/bpk_checker.sv */
`default_nettype none

module bpk_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [bpk_pkg::ByteWidth-1:0] rsp_out_byte,
   input wire logic                          rsp_is_final
);

   // A stalled output word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_is_final))
      else $error("output word changed while stalled");

   // Reset empties the output register.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   // An output word appearing from an idle output follows an accepted input word.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("output word without a matching input word");

   // A held output and a full input stage stall the input.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && $past(req_valid && req_ready) && $past(rsp_valid && !rsp_ready)
      |-> !req_ready)
      else $error("input accepted while the pipeline is full");

endmodule

bind lsb_first_bit_packer_top bpk_checker u_bpk_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_out_byte (rsp.out_byte),
   .rsp_is_final (rsp.is_final)
);

`default_nettype wire

/* tb/sv/packed_byte_checker.sv */
`timescale 1ns / 100ps

module packed_byte_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [bpk_pkg::ModeWidth-1:0]       req_mode,
   input  logic [bpk_pkg::ByteWidth-1:0]       req_data_byte,
   input  logic [bpk_pkg::CountWidth-1:0]      req_bit_count,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [bpk_pkg::ByteWidth-1:0]       rsp_out_byte,
   input  logic                                rsp_is_final,
   output int                                  rsp_mismatches,
   output int                                  rsp_outstanding
);
   import bpk_pkg::*;

   logic [ByteWidth-1:0] held_bits;
   logic [PosWidth-1:0]  held_count;
   result_type           packed_bytes[$];
   int                   mismatch_total;

   initial begin
      held_bits       = '0;
      held_count      = '0;
      mismatch_total  = 0;
      rsp_mismatches  = 0;
      rsp_outstanding = 0;
   end

   // Adds n (1 to 8) bits at the current position; returns 1 when a byte fills.
   function automatic bit append_bits(input logic [ByteWidth-1:0] bits, input int n,
                                      output result_type done);
      logic [ByteWidth-1:0]   mask;
      logic [2*ByteWidth-1:0] acc;
      int                     total;
      mask  = 8'hFF >> (8 - n);
      acc   = {8'h00, held_bits} | ({8'h00, bits & mask} << held_count);
      total = int'(held_count) + n;
      done  = '0;
      if (total >= 8) begin
         done.out_byte = acc[ByteWidth-1:0];
         held_bits     = acc[2*ByteWidth-1:ByteWidth];
         held_count    = PosWidth'(total - 8);
         return 1'b1;
      end
      held_bits  = acc[ByteWidth-1:0];
      held_count = PosWidth'(total);
      return 1'b0;
   endfunction

   // Advances the packing state by one word; returns 1 when a byte comes out.
   function automatic bit pack_word(input item_type word, output result_type done);
      int n;
      bit flushing;
      done = '0;
      n    = 0;
      case (word.mode)
         MODE_BIT: n = ONE_BIT;
         MODE_BYTE: n = FULL_BYTE_BITS;
         MODE_CHUNK: begin
            n = (word.bit_count > FULL_BYTE_BITS) ? FULL_BYTE_BITS : word.bit_count;
         end
         MODE_ALIGNED: begin
            done.out_byte = word.data_byte;
            held_bits     = '0;
            return 1'b1;
         end
         MODE_FLUSH: begin
            flushing = (held_count != 0);
            if (flushing) begin
               done.out_byte = held_bits;
               done.is_final = 1'b1;
            end
            held_bits  = '0;
            held_count = '0;
            return flushing;
         end
         default: ;
      endcase
      if (n == 0)
         return 1'b0;
      return append_bits(word.data_byte, n, done);
   endfunction

   always @(posedge clock) begin : watch
      item_type   word;
      result_type got;
      result_type want;
      if (reset) begin
         held_bits  = '0;
         held_count = '0;
         packed_bytes.delete();
      end else begin
         // A byte can never belong to a word taken at the same edge, so the
         // output side is checked before the new word is predicted.
         if (rsp_valid && rsp_ready) begin
            got.out_byte = rsp_out_byte;
            got.is_final = rsp_is_final;
            if (packed_bytes.size() == 0) begin
               $display("%0t: unexpected byte: expected none, actual byte %h final %b",
                        $time, got.out_byte, got.is_final);
               mismatch_total++;
            end else begin
               want = packed_bytes.pop_front();
               if (got.out_byte !== want.out_byte || got.is_final !== want.is_final) begin
                  $display("%0t: mismatch: expected byte %h final %b, actual byte %h final %b",
                           $time, want.out_byte, want.is_final, got.out_byte, got.is_final);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            word.mode      = req_mode;
            word.data_byte = req_data_byte;
            word.bit_count = req_bit_count;
            if (pack_word(word, want))
               packed_bytes.push_back(want);
         end
      end
      rsp_outstanding <= packed_bytes.size();
      rsp_mismatches  <= mismatch_total;
   end

endmodule

/* tb/sv/tb_lsb_first_bit_packer_top.sv */
`timescale 1ns / 100ps

module tb_lsb_first_bit_packer_top;
   import bpk_pkg::*;

   localparam logic [ModeWidth-1:0] FIRST_SPARE_MODE = 3'd5;
   localparam int                   WORDS_TO_SEND    = 1200;

   logic clock    = 1'b0;
   logic reset    = 1'b1;
   logic steady   = 1'b0;
   logic req_fire = 1'b0;
   int   rsp_mismatches;
   int   rsp_outstanding;

   bpk_req_if req_ch ();
   bpk_rsp_if rsp_ch ();

   lsb_first_bit_packer_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   packed_byte_checker watcher (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_mode        (req_ch.mode),
      .req_data_byte   (req_ch.data_byte),
      .req_bit_count   (req_ch.bit_count),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_out_byte    (rsp_ch.out_byte),
      .rsp_is_final    (rsp_ch.is_final),
      .rsp_mismatches  (rsp_mismatches),
      .rsp_outstanding (rsp_outstanding)
   );

   always #4 clock = ~clock;

   // Records whether a word was taken at the last rising edge.
   always @(posedge clock) begin
      req_fire <= req_ch.valid && req_ch.ready;
   end

   initial rsp_ch.ready = 1'b0;

   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 32);
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   task automatic send_word(input logic [ModeWidth-1:0] mode,
                            input logic [ByteWidth-1:0] data,
                            input logic [CountWidth-1:0] count);
      while (!steady && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= mode;
      req_ch.data_byte <= data;
      req_ch.bit_count <= count;
      do @(negedge clock); while (!req_fire);
   endtask

   // Sends one random word; returns 0 for a spare mode, which the block ignores.
   task automatic send_random_word(output bit counted);
      int                    pick;
      int                    span;
      logic [CountWidth-1:0] count;
      logic [ModeWidth-1:0]  mode;
      pick    = $urandom_range(99);
      span    = $urandom_range(99);
      count   = CountWidth'($urandom_range(1, 8));
      counted = 1'b1;
      if (pick < 22)
         mode = MODE_BIT;
      else if (pick < 40)
         mode = MODE_BYTE;
      else if (pick < 50)
         mode = MODE_ALIGNED;
      else if (pick < 85) begin
         mode = MODE_CHUNK;
         if (span < 8)
            count = '0;
         else if (span < 16)
            count = CountWidth'($urandom_range(9, 15));
      end else if (pick < 96)
         mode = MODE_FLUSH;
      else begin
         mode    = FIRST_SPARE_MODE + ModeWidth'($urandom_range(2));
         counted = 1'b0;
      end
      if (mode != MODE_CHUNK && span < 50)
         count = CountWidth'($urandom_range(15));
      send_word(mode, ByteWidth'($urandom_range(255)), count);
   endtask

   initial begin
      int sent;
      bit counted;
      req_ch.valid     = 1'b0;
      req_ch.mode      = MODE_BIT;
      req_ch.data_byte = '0;
      req_ch.bit_count = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed words: each mode, field extremes and the corner cases.
      send_word(MODE_FLUSH, 8'hFF, 4'hF);
      send_word(MODE_BIT, 8'hFF, 4'h0);
      send_word(MODE_BIT, 8'hFE, 4'hF);
      send_word(MODE_BYTE, 8'hA5, 4'h0);
      send_word(MODE_CHUNK, 8'hFF, 4'd3);
      send_word(MODE_CHUNK, 8'hFF, 4'd0);
      send_word(MODE_ALIGNED, 8'h3C, 4'hF);
      send_word(FIRST_SPARE_MODE, 8'hFF, 4'hF);
      send_word(FIRST_SPARE_MODE + 3'd1, 8'h00, 4'h0);
      send_word(FIRST_SPARE_MODE + 3'd2, 8'h5A, 4'd8);
      send_word(MODE_CHUNK, 8'hFF, 4'hF);
      send_word(MODE_CHUNK, 8'hAA, 4'd9);
      send_word(MODE_CHUNK, 8'h00, 4'd8);
      send_word(MODE_FLUSH, 8'h00, 4'h0);
      send_word(MODE_BYTE, 8'h00, 4'hF);
      send_word(MODE_BYTE, 8'hFF, 4'h0);
      send_word(MODE_CHUNK, 8'h80, 4'd1);
      send_word(MODE_CHUNK, 8'h7F, 4'd7);
      send_word(MODE_CHUNK, 8'hF0, 4'd4);
      send_word(MODE_ALIGNED, 8'hFF, 4'h0);
      send_word(MODE_ALIGNED, 8'h00, 4'h0);
      send_word(MODE_BIT, 8'h01, 4'h0);
      send_word(MODE_FLUSH, 8'hFF, 4'hF);
      send_word(MODE_FLUSH, 8'h00, 4'h0);

      sent = 0;
      while (sent < WORDS_TO_SEND) begin
         if (sent == 300) begin
            // Hold off until every byte owed so far has been taken.
            req_ch.valid <= 1'b0;
            do @(negedge clock); while (rsp_outstanding != 0);
         end
         steady <= (sent >= 600 && sent < 800);
         send_random_word(counted);
         if (counted)
            sent++;
      end
      req_ch.valid <= 1'b0;
      steady       <= 1'b0;

      do @(negedge clock); while (rsp_outstanding != 0);
      repeat (16) @(negedge clock);
      if (rsp_mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
sv/bpk_pkg.sv
sv/bpk_req_if.sv
sv/bpk_rsp_if.sv
sv/bpk_in_stage.sv
sv/bpk_pack_core.sv
sv/lsb_first_bit_packer_top.sv
sv/bpk_checker.sv
tb/sv/packed_byte_checker.sv
tb/sv/tb_lsb_first_bit_packer_top.sv
